// File: design/lir_pkg.sv
`timescale 1ns / 1ps

package lir_pkg;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DIVIDE,
    ST_ISSUE,
    ST_WAIT
  } lir_state_t;

  // register select, taken from paddr[2]
  localparam logic REG_IN_LENGTH  = 1'b0;
  localparam logic REG_OUT_LENGTH = 1'b1;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 16;
  localparam int INDEX_W  = 6;
  localparam int IN_LEN_W  = 9;
  localparam int OUT_LEN_W = 7;

  typedef struct packed {
    logic                vld;
    logic                last;
    logic [INDEX_W-1:0]  idx;
    logic [FRAC_W-1:0]   frac;
  } calc_req_t;

  typedef struct packed {
    logic                vld;
    logic                last;
    logic [INDEX_W-1:0]  idx;
    logic [SAMPLE_W-1:0] value;
  } calc_res_t;

endpackage

// File: design/linear_interp_resampler_unit.sv
`timescale 1ns / 1ps

// Linear interpolation resampler. Samples arrive one per cycle on the slave
// stream and go into an internal sample memory; s_tready is high only while
// loading. When in_length samples are in, the block divides in_length*65536
// by out_length in a bit-serial divider, then produces out_length values one
// at a time: each value passes through address issue, memory read, multiply,
// sum and output transaction, and only one output is in flight through the
// read and multiply path; the next address is issued after the master side
// takes the previous value. Loading of the next vector starts after the last
// value is taken. The lengths are written over the APB port at 0x0
// (in_length) and 0x4 (out_length); zero acts as one and values above MAX_IN
// or MAX_OUT are clamped.
module linear_interp_resampler_unit #(
  parameter int MAX_IN  = 256,
  parameter int MAX_OUT = 64
) (
  input  logic        clk,
  input  logic        rst,
  // apb
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // sample[15:0]
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // value[15:0], out_index[21:16], zero[23:22]
  output logic        m_tlast
);

  localparam int AW  = $clog2(MAX_IN);
  localparam int NW  = $clog2(MAX_IN + 1);
  localparam int LW  = (NW > lir_pkg::IN_LEN_W) ? NW : lir_pkg::IN_LEN_W;
  localparam int QW  = NW + lir_pkg::FRAC_W;
  localparam int OLW = lir_pkg::OUT_LEN_W;

  lir_pkg::lir_state_t state, state_next;

  logic [lir_pkg::IN_LEN_W-1:0] in_length;
  logic [OLW-1:0]               out_length;
  logic [AW-1:0]                load_count;
  logic [NW-1:0]                n_in;
  logic [OLW-1:0]               n_out;
  logic [QW-1:0]                step_value;
  logic [QW-1:0]                position_accum;
  logic [lir_pkg::INDEX_W-1:0]  out_idx;

  logic                         cfg_wr;
  logic                         in_xfer;
  logic                         out_xfer;
  logic [LW-1:0]                cnt_inc;
  logic [LW-1:0]                n_in_cur;
  logic [OLW-1:0]               n_out_cur;
  logic                         fire;
  logic                         div_start;
  logic                         div_done;
  logic [QW-1:0]                div_q;
  logic                         issue;

  logic [NW-1:0]                ipos;
  logic [NW-1:0]                last_pos;
  logic [NW-1:0]                li;
  logic [NW:0]                  ri_w;
  logic [NW-1:0]                ri;
  logic                         is_last;

  logic [lir_pkg::SAMPLE_W-1:0] rd_left;
  logic [lir_pkg::SAMPLE_W-1:0] rd_right;
  lir_pkg::calc_req_t           req;
  lir_pkg::calc_res_t           res;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_length  <= 9'd256;
      out_length <= 7'd64;
    end else if (cfg_wr) begin
      if (paddr[2] == lir_pkg::REG_IN_LENGTH) begin
        in_length <= pwdata[lir_pkg::IN_LEN_W-1:0];
      end else begin
        out_length <= pwdata[OLW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == lir_pkg::REG_OUT_LENGTH) begin
      prdata = {{(32-OLW){1'b0}}, out_length};
    end else begin
      prdata = {{(32-lir_pkg::IN_LEN_W){1'b0}}, in_length};
    end
  end

  // effective lengths
  always_comb begin
    if (in_length == '0) begin
      n_in_cur = LW'(1);
    end else if (LW'(in_length) > LW'(MAX_IN)) begin
      n_in_cur = LW'(MAX_IN);
    end else begin
      n_in_cur = LW'(in_length);
    end
    if (out_length == '0) begin
      n_out_cur = OLW'(1);
    end else if (out_length > OLW'(MAX_OUT)) begin
      n_out_cur = OLW'(MAX_OUT);
    end else begin
      n_out_cur = out_length;
    end
  end

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;
  assign cnt_inc  = LW'(load_count) + LW'(1);
  assign fire     = in_xfer && (cnt_inc >= n_in_cur);

  // position to sample addresses
  assign ipos     = position_accum[QW-1:lir_pkg::FRAC_W];
  assign last_pos = n_in - NW'(1);
  assign li       = (ipos > last_pos) ? last_pos : ipos;
  assign ri_w     = {1'b0, ipos} + (NW+1)'(1);
  assign ri       = (ri_w > {1'b0, last_pos}) ? last_pos : ri_w[NW-1:0];
  assign is_last  = ({1'b0, out_idx} == (n_out - OLW'(1)));

  // state machine
  always_comb begin
    state_next = state;
    case (state)
      lir_pkg::ST_LOAD: begin
        if (fire) state_next = lir_pkg::ST_DIVIDE;
      end
      lir_pkg::ST_DIVIDE: begin
        if (div_done) state_next = lir_pkg::ST_ISSUE;
      end
      lir_pkg::ST_ISSUE: begin
        state_next = lir_pkg::ST_WAIT;
      end
      lir_pkg::ST_WAIT: begin
        if (out_xfer) begin
          state_next = m_tlast ? lir_pkg::ST_LOAD : lir_pkg::ST_ISSUE;
        end
      end
      default: state_next = lir_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    issue     = 1'b0;
    div_start = 1'b0;
    case (state)
      lir_pkg::ST_LOAD: begin
        s_tready  = 1'b1;
        div_start = fire;
      end
      lir_pkg::ST_ISSUE: issue = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lir_pkg::ST_LOAD;
      load_count <= '0;
      req.vld    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state   <= state_next;
      req.vld <= issue;
      if (in_xfer) begin
        load_count <= fire ? '0 : cnt_inc[AW-1:0];
      end
      if (res.vld) begin
        m_tvalid <= 1'b1;
      end else if (out_xfer) begin
        m_tvalid <= 1'b0;
      end
    end
    req.last <= is_last;
    req.idx  <= out_idx;
    req.frac <= position_accum[lir_pkg::FRAC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      n_in  <= NW'(n_in_cur);
      n_out <= n_out_cur;
    end
    if (div_done) begin
      step_value     <= div_q;
      position_accum <= '0;
      out_idx        <= '0;
    end else if (issue) begin
      position_accum <= position_accum + step_value;
      out_idx        <= out_idx + 1'b1;
    end
    if (res.vld) begin
      m_tdata <= {2'b00, res.idx, res.value};
      m_tlast <= res.last;
    end
  end

  lir_ram #(
    .WIDTH (lir_pkg::SAMPLE_W),
    .DEPTH (MAX_IN)
  ) u_store (
    .clk     (clk),
    .we      (in_xfer),
    .waddr   (load_count),
    .wdata   (s_tdata),
    .raddr_a (li[AW-1:0]),
    .raddr_b (ri[AW-1:0]),
    .rdata_a (rd_left),
    .rdata_b (rd_right)
  );

  lir_div #(
    .INW (NW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .n_in     (NW'(n_in_cur)),
    .n_out    (n_out_cur),
    .done     (div_done),
    .quotient (div_q)
  );

  lir_calc u_calc (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .left  (rd_left),
    .right (rd_right),
    .res   (res)
  );

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res.vld |-> !m_tvalid) else $error("result overwrites pending output");

  a_out_in_wait: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (state == lir_pkg::ST_WAIT)) else $error("output outside wait");

  a_div_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == lir_pkg::ST_DIVIDE)) else $error("divider done out of turn");
`endif

endmodule

// File: design/lir_ram.sv
`timescale 1ns / 1ps

module lir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: design/lir_div.sv
`timescale 1ns / 1ps

module lir_div #(
  parameter int INW = 9
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [INW-1:0]              n_in,
  input  logic [lir_pkg::OUT_LEN_W-1:0] n_out,
  output logic                        done,
  output logic [INW+lir_pkg::FRAC_W-1:0] quotient
);

  localparam int QW   = INW + lir_pkg::FRAC_W;
  localparam int DW   = lir_pkg::OUT_LEN_W;
  localparam int CNTW = $clog2(QW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   divisor;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            qbit;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, quotient[QW-1]};
  assign qbit  = (trial >= {1'b0, divisor});
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= {n_in, {lir_pkg::FRAC_W{1'b0}}};
      rem      <= '0;
      divisor  <= n_out;
    end else if (busy) begin
      quotient <= {quotient[QW-2:0], qbit};
      rem      <= qbit ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

endmodule

// File: design/lir_calc.sv
`timescale 1ns / 1ps

module lir_calc (
  input  logic                          clk,
  input  logic                          rst,
  input  lir_pkg::calc_req_t            req,
  input  logic [lir_pkg::SAMPLE_W-1:0]  left,
  input  logic [lir_pkg::SAMPLE_W-1:0]  right,
  output lir_pkg::calc_res_t            res
);

  logic [lir_pkg::FRAC_W:0] wl;
  logic signed [17:0]       wl_s;
  logic signed [17:0]       wr_s;
  logic signed [33:0]       pl_c;
  logic signed [33:0]       pr_c;
  logic signed [33:0]       pl;
  logic signed [33:0]       pr;
  logic                     vld1;
  logic                     last1;
  logic [lir_pkg::INDEX_W-1:0] idx1;
  logic signed [34:0]       sum;
  logic signed [34:0]       adj;

  assign wl   = 17'h10000 - {1'b0, req.frac};
  assign wl_s = $signed({1'b0, wl});
  assign wr_s = $signed({2'b00, req.frac});
  assign pl_c = $signed(left) * wl_s;
  assign pr_c = $signed(right) * wr_s;

  // truncate toward zero: bias negative sums before the shift
  assign sum = {pl[33], pl} + {pr[33], pr};
  assign adj = sum + (sum[34] ? 35'sh0FFFF : 35'sh0);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      res.vld <= 1'b0;
    end else begin
      vld1    <= req.vld;
      res.vld <= vld1;
    end
    pl        <= pl_c;
    pr        <= pr_c;
    last1     <= req.last;
    idx1      <= req.idx;
    res.last  <= last1;
    res.idx   <= idx1;
    res.value <= adj[31:16];
  end

endmodule
